// ===== design/tim_dec_pkg.sv =====
package tim_dec_pkg;

    // Parse phases of the file walk
    typedef enum logic [3:0] {
        PH_MAGIC,
        PH_FLAGS,
        PH_CLUT_SIZE,
        PH_CLUT_XY,
        PH_CLUT_WH,
        PH_CLUT_DATA,
        PH_IMG_SIZE,
        PH_IMG_XY,
        PH_IMG_WH,
        PH_PIXELS,
        PH_DONE,
        PH_ERROR
    } phase_t;

    localparam logic [31:0] MAGIC_WORD  = 32'h0000_0010;
    localparam logic [2:0]  DEPTH_8BPP  = 3'd1;
    localparam logic [2:0]  DEPTH_16BPP = 3'd2;
    localparam int unsigned FLAG_CLUT   = 3;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;
    localparam logic [7:0]  ALPHA_CLEAR  = 8'd0;

    // One result in flight: either a palette lookup or a direct colour
    typedef struct packed {
        logic        kind;
        logic        direct;
        logic        hit;
        logic [15:0] value;
        logic [17:0] column;
        logic [15:0] row;
        logic [2:0]  depth;
        logic        last;
    } job_t;

    // Finished result as shown on the output port
    typedef struct packed {
        logic        kind;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [7:0]  alpha;
        logic [17:0] column;
        logic [15:0] row;
        logic [2:0]  depth;
        logic        last;
    } res_t;

endpackage

// ===== design/tim_dec_parser.sv =====
module tim_dec_parser #(
    parameter int unsigned ENTRIES = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        src_valid,
    output logic                        src_ready,
    input  logic [7:0]                  data_byte,
    input  logic                        file_start,
    input  logic                        job_ready,
    output logic                        job_valid,
    output tim_dec_pkg::job_t           job,
    output logic                        wr_en,
    output logic [$clog2(ENTRIES)-1:0]  wr_addr,
    output logic [15:0]                 wr_data
);
    import tim_dec_pkg::*;

    localparam int unsigned IDX_W  = $clog2(ENTRIES);
    localparam int unsigned FILL_W = $clog2(ENTRIES + 1);

    phase_t             phase_reg, phase_next;
    logic [1:0]         bidx_reg, bidx_next;
    logic [23:0]        asm_reg, asm_next;
    logic [3:0]         flags_reg, flags_next;
    logic [31:0]        rem_reg, rem_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [17:0]        rowpix_reg, rowpix_next;
    logic [15:0]        height_reg, height_next;
    logic [17:0]        col_reg, col_next;
    logic [15:0]        row_reg, row_next;
    logic               pend_reg, pend_next;
    logic [3:0]         nib_reg, nib_next;

    logic               acc;
    phase_t             phase_cur;
    logic [1:0]         bidx_cur;
    logic [23:0]        asm_cur;
    logic [FILL_W-1:0]  fill_cur;
    logic [31:0]        word;
    logic               word_done;
    logic [31:0]        prod;
    logic [2:0]         depth;
    logic               is4;
    logic               pend_issue;
    logic               pix_acc;
    logic               emit_go;
    logic               err_go;
    logic [15:0]        emit_val;
    logic [18:0]        col_inc;
    logic               last;
    logic               wrap;
    logic               clut_write;

    // Effective state: a file start restarts the parse on this beat
    assign acc       = src_valid && src_ready;
    assign phase_cur = file_start ? PH_MAGIC : phase_reg;
    assign bidx_cur  = file_start ? 2'd0 : bidx_reg;
    assign asm_cur   = file_start ? 24'd0 : asm_reg;
    assign fill_cur  = file_start ? FILL_W'(0) : fill_reg;
    assign word      = {data_byte, asm_cur};
    assign word_done = (bidx_cur == 2'd3);
    assign prod      = word[15:0] * word[31:16];
    assign depth     = flags_reg[2:0];
    assign is4       = (depth != DEPTH_8BPP) && (depth != DEPTH_16BPP);

    // Pixel emission
    assign pend_issue = pend_reg && job_ready;
    assign pix_acc    = acc && (phase_cur == PH_PIXELS);
    assign emit_go    = pend_issue ||
                        (pix_acc && (depth != DEPTH_16BPP || bidx_cur[0]));
    assign err_go     = acc && (phase_cur == PH_MAGIC) && word_done && (word != MAGIC_WORD);

    always_comb
    begin
        if (pend_issue)
            emit_val = {12'd0, nib_reg};
        else if (depth == DEPTH_16BPP)
            emit_val = {data_byte, asm_cur[7:0]};
        else if (depth == DEPTH_8BPP)
            emit_val = {8'd0, data_byte};
        else
            emit_val = {12'd0, data_byte[3:0]};
    end

    assign col_inc = {1'b0, col_reg} + 19'd1;
    assign last    = (({1'b0, row_reg} + 17'd1) == {1'b0, height_reg}) &&
                     (col_inc == {1'b0, rowpix_reg});
    assign wrap    = (col_inc >= {1'b0, rowpix_reg});

    // Job to the palette stage
    always_comb
    begin
        job_valid = emit_go || err_go;
        job       = '0;
        if (!err_go)
        begin
            job.direct = !pend_issue && (depth == DEPTH_16BPP);
            job.hit    = (32'(emit_val[7:0]) < 32'(fill_reg));
            job.value  = emit_val;
            job.column = col_reg;
            job.row    = row_reg;
            job.depth  = depth;
            job.last   = last;
        end
        else
        begin
            job.kind   = 1'b1;
            job.direct = 1'b1;
        end
    end

    assign src_ready = !pend_reg && job_ready;

    // Palette store writes
    assign clut_write = acc && (phase_cur == PH_CLUT_DATA) && bidx_cur[0];
    assign wr_en      = clut_write && (fill_cur < FILL_W'(ENTRIES));
    assign wr_addr    = fill_cur[IDX_W-1:0];
    assign wr_data    = {data_byte, asm_cur[7:0]};

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (pend_issue)
        begin
            if (last)
                phase_next = PH_DONE;
        end
        else if (acc)
        begin
            phase_next = phase_cur;
            unique case (phase_cur)
                PH_MAGIC:
                    if (word_done)
                        phase_next = (word == MAGIC_WORD) ? PH_FLAGS : PH_ERROR;
                PH_FLAGS:
                    if (word_done)
                        phase_next = word[FLAG_CLUT] ? PH_CLUT_SIZE : PH_IMG_SIZE;
                PH_CLUT_SIZE:
                    if (word_done)
                        phase_next = PH_CLUT_XY;
                PH_CLUT_XY:
                    if (word_done)
                        phase_next = PH_CLUT_WH;
                PH_CLUT_WH:
                    if (word_done)
                        phase_next = (prod != 32'd0) ? PH_CLUT_DATA : PH_IMG_SIZE;
                PH_CLUT_DATA:
                    if (bidx_cur[0] && rem_reg == 32'd1)
                        phase_next = PH_IMG_SIZE;
                PH_IMG_SIZE:
                    if (word_done)
                        phase_next = PH_IMG_XY;
                PH_IMG_XY:
                    if (word_done)
                        phase_next = PH_IMG_WH;
                PH_IMG_WH:
                    if (word_done)
                        phase_next = (word[15:0] != 16'd0 && word[31:16] != 16'd0) ?
                                     PH_PIXELS : PH_DONE;
                PH_PIXELS:
                    if (emit_go && last)
                        phase_next = PH_DONE;
                PH_DONE,
                PH_ERROR:
                    phase_next = phase_cur;
                default:
                    phase_next = PH_MAGIC;
            endcase
        end
    end

    // Field assembly, counters and palette bookkeeping
    always_comb
    begin
        bidx_next   = bidx_reg;
        asm_next    = asm_reg;
        flags_next  = flags_reg;
        rem_next    = rem_reg;
        fill_next   = fill_reg;
        rowpix_next = rowpix_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        pend_next   = pend_reg;
        nib_next    = nib_reg;

        if (acc)
        begin
            bidx_next = bidx_cur;
            asm_next  = asm_cur;
            fill_next = fill_cur;
            if (file_start)
                flags_next = 4'd0;

            case (phase_cur)
                PH_MAGIC, PH_FLAGS, PH_CLUT_SIZE, PH_CLUT_XY, PH_CLUT_WH,
                PH_IMG_SIZE, PH_IMG_XY, PH_IMG_WH:
                begin
                    if (word_done)
                    begin
                        bidx_next = 2'd0;
                        asm_next  = 24'd0;
                    end
                    else
                    begin
                        bidx_next = bidx_cur + 2'd1;
                        case (bidx_cur)
                            2'd0:    asm_next[7:0]   = data_byte;
                            2'd1:    asm_next[15:8]  = data_byte;
                            default: asm_next[23:16] = data_byte;
                        endcase
                    end
                    if (word_done && phase_cur == PH_FLAGS)
                        flags_next = word[3:0];
                    if (word_done && phase_cur == PH_CLUT_WH)
                        rem_next = prod;
                    if (word_done && phase_cur == PH_IMG_WH)
                    begin
                        height_next = word[31:16];
                        col_next    = 18'd0;
                        row_next    = 16'd0;
                        if (depth == DEPTH_8BPP)
                            rowpix_next = {1'b0, word[15:0], 1'b0};
                        else if (depth == DEPTH_16BPP)
                            rowpix_next = {2'b00, word[15:0]};
                        else
                            rowpix_next = {word[15:0], 2'b00};
                    end
                end
                PH_CLUT_DATA:
                begin
                    if (!bidx_cur[0])
                    begin
                        asm_next  = {16'd0, data_byte};
                        bidx_next = 2'd1;
                    end
                    else
                    begin
                        asm_next  = 24'd0;
                        bidx_next = 2'd0;
                        rem_next  = rem_reg - 32'd1;
                        if (wr_en)
                            fill_next = fill_cur + FILL_W'(1);
                    end
                end
                PH_PIXELS:
                begin
                    if (depth == DEPTH_16BPP)
                    begin
                        if (!bidx_cur[0])
                        begin
                            asm_next  = {16'd0, data_byte};
                            bidx_next = 2'd1;
                        end
                        else
                        begin
                            asm_next  = 24'd0;
                            bidx_next = 2'd0;
                        end
                    end
                    else if (is4 && !last)
                    begin
                        pend_next = 1'b1;
                        nib_next  = data_byte[7:4];
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (pend_issue)
            pend_next = 1'b0;

        // Advance pixel position
        if (emit_go)
        begin
            if (wrap)
            begin
                col_next = 18'd0;
                row_next = row_reg + 16'd1;
            end
            else
            begin
                col_next = col_inc[17:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_MAGIC;
            bidx_reg   <= 2'd0;
            asm_reg    <= 24'd0;
            flags_reg  <= 4'd0;
            rem_reg    <= 32'd0;
            fill_reg   <= '0;
            rowpix_reg <= 18'd0;
            height_reg <= 16'd0;
            col_reg    <= 18'd0;
            row_reg    <= 16'd0;
            pend_reg   <= 1'b0;
            nib_reg    <= 4'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            bidx_reg   <= bidx_next;
            asm_reg    <= asm_next;
            flags_reg  <= flags_next;
            rem_reg    <= rem_next;
            fill_reg   <= fill_next;
            rowpix_reg <= rowpix_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            pend_reg   <= pend_next;
            nib_reg    <= nib_next;
        end
    end

endmodule

// ===== design/tim_dec_palette.sv =====
module tim_dec_palette #(
    parameter int unsigned ENTRIES = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        job_valid,
    input  tim_dec_pkg::job_t           job,
    output logic                        job_ready,
    input  logic                        wr_en,
    input  logic [$clog2(ENTRIES)-1:0]  wr_addr,
    input  logic [15:0]                 wr_data,
    input  logic                        space,
    output logic                        a_valid,
    output tim_dec_pkg::job_t           a_job,
    output logic [15:0]                 rd_data
);
    import tim_dec_pkg::*;

    localparam int unsigned IDX_W = $clog2(ENTRIES);

    logic [15:0]      mem [ENTRIES];
    logic             a_valid_reg, a_valid_next;
    job_t             a_job_reg;
    logic [15:0]      rd_data_reg;
    logic             load;
    logic             a_take;
    logic [IDX_W-1:0] rd_addr;

    // Read stage holds while the result queue is full
    assign a_take    = a_valid_reg && space;
    assign job_ready = !a_valid_reg || space;
    assign load      = job_valid && job_ready;
    assign rd_addr   = IDX_W'(job.value[7:0]);

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (load)
            a_valid_next = 1'b1;
        else if (a_take)
            a_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= a_valid_next;
    end

    // Palette memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (load)
        begin
            rd_data_reg <= mem[rd_addr];
            a_job_reg   <= job;
        end
    end

    assign a_valid = a_valid_reg;
    assign a_job   = a_job_reg;
    assign rd_data = rd_data_reg;

endmodule

// ===== design/tim_dec_out.sv =====
module tim_dec_out (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               a_valid,
    input  tim_dec_pkg::job_t  a_job,
    input  logic [15:0]        rd_data,
    output logic               space,
    output logic               res_valid,
    input  logic               res_ready,
    output logic               kind,
    output logic [7:0]         blue,
    output logic [7:0]         green,
    output logic [7:0]         red,
    output logic [7:0]         alpha,
    output logic [17:0]        column,
    output logic [15:0]        row,
    output logic [2:0]         depth_code,
    output logic               last_pixel
);
    import tim_dec_pkg::*;

    res_t        q_reg [2];
    logic [1:0]  count_reg, count_next;
    logic        wptr_reg, rptr_reg;
    logic        push, pop;
    logic [15:0] color;
    res_t        res;
    res_t        head;

    assign space = (count_reg != 2'd2);
    assign push  = a_valid && space;
    assign pop   = res_valid && res_ready;

    // Colour expansion: lookup miss reads as a cleared entry
    always_comb
    begin
        if (a_job.direct)
            color = a_job.value;
        else if (a_job.hit)
            color = rd_data;
        else
            color = 16'd0;
        res.kind   = a_job.kind;
        res.blue   = {color[4:0], 3'b000};
        res.green  = {color[9:5], 3'b000};
        res.red    = {color[14:10], 3'b000};
        res.alpha  = (a_job.kind || color[15]) ? ALPHA_CLEAR : ALPHA_OPAQUE;
        res.column = a_job.column;
        res.row    = a_job.row;
        res.depth  = a_job.depth;
        res.last   = a_job.last;
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    // Two-beat result queue parts the pipeline from the consumer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wptr_reg <= !wptr_reg;
            if (pop)
                rptr_reg <= !rptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wptr_reg] <= res;
    end

    assign head       = q_reg[rptr_reg];
    assign res_valid  = (count_reg != 2'd0);
    assign kind       = head.kind;
    assign blue       = head.blue;
    assign green      = head.green;
    assign red        = head.red;
    assign alpha      = head.alpha;
    assign column     = head.column;
    assign row        = head.row;
    assign depth_code = head.depth;
    assign last_pixel = head.last;

endmodule

// ===== design/tim_image_stream_decoder_top.sv =====
// TIM image stream decoder. Takes the file one byte per beat and returns decoded pixels
// (or one error beat on a bad magic word); file_start on a byte restarts the parse at
// that byte. Header and palette bytes are taken one per cycle while the pipeline is not
// held by back-pressure; so is a byte at 8bpp, and at 16bpp with one pixel per two bytes.
// At 4bpp the next byte waits while the high nibble of a byte is pending, because both
// nibbles go through the single read port of the palette memory. A result passes the
// palette read register and the result queue before it leaves; the high nibble of a 4bpp
// byte follows the low one. The palette needs no clearing pass: a fill count marks which
// entries this file has written, and any other entry reads as zero colour.
module tim_image_stream_decoder_top #(
    parameter int unsigned PALETTE_ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    output logic        src_ready,
    input  logic [7:0]  data_byte,
    input  logic        file_start,
    output logic        res_valid,
    input  logic        res_ready,
    output logic        kind,
    output logic [7:0]  blue,
    output logic [7:0]  green,
    output logic [7:0]  red,
    output logic [7:0]  alpha,
    output logic [17:0] column,
    output logic [15:0] row,
    output logic [2:0]  depth_code,
    output logic        last_pixel
);
    import tim_dec_pkg::*;

    localparam int unsigned IDX_W = $clog2(PALETTE_ENTRIES);

    logic             job_valid;
    logic             job_ready;
    job_t             job;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [15:0]      wr_data;
    logic             space;
    logic             a_valid;
    job_t             a_job;
    logic [15:0]      rd_data;

    tim_dec_parser #(
        .ENTRIES (PALETTE_ENTRIES)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_ready  (src_ready),
        .data_byte  (data_byte),
        .file_start (file_start),
        .job_ready  (job_ready),
        .job_valid  (job_valid),
        .job        (job),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    tim_dec_palette #(
        .ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_ready (job_ready),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .space     (space),
        .a_valid   (a_valid),
        .a_job     (a_job),
        .rd_data   (rd_data)
    );

    tim_dec_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .a_valid    (a_valid),
        .a_job      (a_job),
        .rd_data    (rd_data),
        .space      (space),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .kind       (kind),
        .blue       (blue),
        .green      (green),
        .red        (red),
        .alpha      (alpha),
        .column     (column),
        .row        (row),
        .depth_code (depth_code),
        .last_pixel (last_pixel)
    );

    // A job is only offered when the read stage can take it
    a_job_taken: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> job_ready)
        else $error("job offered while read stage busy");

    // Palette loads never overlap a palette read
    a_no_wr_rd: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !job_valid)
        else $error("palette write collides with read");

    // Error beat carries a cleared payload
    a_err_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && kind) |-> (alpha == 8'd0 && blue == 8'd0 && column == 18'd0 &&
                                 row == 16'd0 && last_pixel == 1'b0))
        else $error("error beat with nonzero payload");

endmodule

// ===== bench/tim_image_stream_decoder_top_tb.sv =====
`timescale 1ns / 100ps

module tim_image_stream_decoder_top_tb;
    import tim_dec_pkg::*;

    localparam int unsigned BYTE_TARGET = 1900;
    localparam int unsigned IDLE_LIMIT  = 2000;
    localparam int unsigned DRAIN_WAIT  = 20;

    // Pixel predictor and queue of the pixels still owed by the decoder
    class tim_pixel_board;
        localparam int unsigned CLUT_ENTRIES = 256;

        phase_t      phase;
        int unsigned byte_idx;
        int unsigned word_acc;
        int unsigned flags;
        int unsigned clut_left;
        int unsigned clut_wr;
        int unsigned img_w;
        int unsigned img_h;
        int unsigned col_cnt;
        int unsigned row_cnt;
        logic [15:0] clut [CLUT_ENTRIES];
        res_t        owed_pixels[$];
        int unsigned errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            phase     = PH_MAGIC;
            byte_idx  = 0;
            word_acc  = 0;
            flags     = 0;
            clut_left = 0;
            clut_wr   = 0;
            img_w     = 0;
            img_h     = 0;
            col_cnt   = 0;
            row_cnt   = 0;
            foreach (clut[i])
                clut[i] = '0;
        endfunction

        // Little-endian word assembly, one byte per call; 1 when the word is complete
        function bit grab(logic [7:0] b);
            word_acc |= {24'b0, b} << (8 * byte_idx);
            if (byte_idx == 3)
            begin
                byte_idx = 0;
                return 1'b1;
            end
            byte_idx++;
            return 1'b0;
        endfunction

        function int unsigned row_len();
            if (flags[2:0] == DEPTH_8BPP)
                return img_w * 2;
            if (flags[2:0] == DEPTH_16BPP)
                return img_w;
            return img_w * 4;
        endfunction

        function logic [15:0] lookup(int unsigned idx);
            return (idx < CLUT_ENTRIES) ? clut[idx] : 16'h0000;
        endfunction

        // One pixel at the current position, then step the position
        function void emit(logic [15:0] c);
            res_t        r;
            int unsigned w;
            bit          last;
            w         = row_len();
            last      = (row_cnt + 1 == img_h) && (col_cnt + 1 == w);
            r.kind    = 1'b0;
            r.blue    = {c[4:0], 3'b000};
            r.green   = {c[9:5], 3'b000};
            r.red     = {c[14:10], 3'b000};
            r.alpha   = c[15] ? ALPHA_CLEAR : ALPHA_OPAQUE;
            r.column  = col_cnt[17:0];
            r.row     = row_cnt[15:0];
            r.depth   = flags[2:0];
            r.last    = last;
            owed_pixels.push_back(r);
            col_cnt++;
            if (col_cnt >= w)
            begin
                col_cnt = 0;
                row_cnt++;
            end
            if (last)
                phase = PH_DONE;
        endfunction

        // Note one accepted byte and queue the pixels it yields
        function void take_byte(logic [7:0] b, logic start);
            res_t err;
            if (start)
                clear();
            case (phase)
                PH_MAGIC:
                begin
                    if (grab(b))
                    begin
                        if (word_acc != MAGIC_WORD)
                        begin
                            err      = '0;
                            err.kind = 1'b1;
                            owed_pixels.push_back(err);
                            phase = PH_ERROR;
                        end
                        else
                            phase = PH_FLAGS;
                        word_acc = 0;
                    end
                end
                PH_FLAGS:
                begin
                    if (grab(b))
                    begin
                        flags    = word_acc & 32'hF;
                        phase    = flags[FLAG_CLUT] ? PH_CLUT_SIZE : PH_IMG_SIZE;
                        word_acc = 0;
                    end
                end
                PH_CLUT_SIZE, PH_CLUT_XY, PH_IMG_SIZE, PH_IMG_XY:
                begin
                    if (grab(b))
                    begin
                        phase    = phase.next();
                        word_acc = 0;
                    end
                end
                PH_CLUT_WH:
                begin
                    if (grab(b))
                    begin
                        clut_left = word_acc[15:0] * word_acc[31:16];
                        clut_wr   = 0;
                        phase     = (clut_left != 0) ? PH_CLUT_DATA : PH_IMG_SIZE;
                        word_acc  = 0;
                    end
                end
                PH_CLUT_DATA:
                begin
                    if (byte_idx == 0)
                    begin
                        word_acc = 32'(b);
                        byte_idx = 1;
                    end
                    else
                    begin
                        // entries past the store are consumed and dropped
                        if (clut_wr < CLUT_ENTRIES)
                            clut[clut_wr] = {b, word_acc[7:0]};
                        clut_wr++;
                        clut_left--;
                        byte_idx = 0;
                        word_acc = 0;
                        if (clut_left == 0)
                            phase = PH_IMG_SIZE;
                    end
                end
                PH_IMG_WH:
                begin
                    if (grab(b))
                    begin
                        img_w    = word_acc[15:0];
                        img_h    = word_acc[31:16];
                        col_cnt  = 0;
                        row_cnt  = 0;
                        phase    = (img_w != 0 && img_h != 0) ? PH_PIXELS : PH_DONE;
                        word_acc = 0;
                    end
                end
                PH_PIXELS:
                begin
                    if (flags[2:0] == DEPTH_8BPP)
                        emit(lookup(b));
                    else if (flags[2:0] == DEPTH_16BPP)
                    begin
                        if (byte_idx == 0)
                        begin
                            word_acc = 32'(b);
                            byte_idx = 1;
                        end
                        else
                        begin
                            emit({b, word_acc[7:0]});
                            byte_idx = 0;
                            word_acc = 0;
                        end
                    end
                    else
                    begin
                        // 4bpp: low nibble first, high nibble only if the image is not done
                        emit(lookup(b[3:0]));
                        if (phase == PH_PIXELS)
                            emit(lookup(b[7:4]));
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one result beat against the oldest owed pixel
        function void check_pixel(res_t got);
            res_t want;
            if (owed_pixels.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = owed_pixels.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("blue", want.blue, got.blue);
            compare_field("green", want.green, got.green);
            compare_field("red", want.red, got.red);
            compare_field("alpha", want.alpha, got.alpha);
            compare_field("column", want.column, got.column);
            compare_field("row", want.row, got.row);
            compare_field("depth_code", want.depth, got.depth);
            compare_field("last_pixel", want.last, got.last);
        endfunction

        function int unsigned pending();
            return owed_pixels.size();
        endfunction
    endclass

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        src_valid  = 1'b0;
    logic        src_ready;
    logic [7:0]  data_byte  = 8'h00;
    logic        file_start = 1'b0;
    logic        res_valid;
    logic        res_ready  = 1'b0;
    logic        kind;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  alpha;
    logic [17:0] column;
    logic [15:0] row;
    logic [2:0]  depth_code;
    logic        last_pixel;

    tim_pixel_board board = new();

    logic [7:0]  file_bytes[$];
    int unsigned bytes_sent = 0;
    int unsigned burst_left = 1;
    int unsigned idle_cycles = 0;
    int unsigned ready_mode = 0;
    int unsigned ready_left = 0;
    int unsigned ready_tick = 0;

    tim_image_stream_decoder_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_ready  (src_ready),
        .data_byte  (data_byte),
        .file_start (file_start),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .kind       (kind),
        .blue       (blue),
        .green      (green),
        .red        (red),
        .alpha      (alpha),
        .column     (column),
        .row        (row),
        .depth_code (depth_code),
        .last_pixel (last_pixel)
    );

    always #5 clk = ~clk;

    // Monitor: note accepted bytes, then check result beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (src_valid && src_ready)
                board.take_byte(data_byte, file_start);
            if (res_valid && res_ready)
                board.check_pixel({kind, blue, green, red, alpha, column, row,
                                   depth_code, last_pixel});
        end
    end

    // Watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((src_valid && src_ready) || (res_valid && res_ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver back-pressure: modes switch after random stretches
    always @(posedge clk)
    begin
        ready_tick <= ready_tick + 1;
        if (ready_left == 0)
        begin
            ready_mode <= $urandom_range(0, 3);
            ready_left <= $urandom_range(10, 150);
        end
        else
            ready_left <= ready_left - 1;
        case (ready_mode)
            0: res_ready <= 1'b1;
            1: res_ready <= 1'($urandom_range(0, 1));
            2: res_ready <= ($urandom_range(0, 7) == 0);
            default: res_ready <= (ready_tick % 5 != 0);
        endcase
    end

    // Drive one byte and wait for its beat; sender may idle between bursts
    task automatic push_byte(input logic [7:0] b, input logic start);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                src_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        src_valid  <= 1'b1;
        data_byte  <= b;
        file_start <= start;
        @(posedge clk);
        while (!src_ready)
            @(posedge clk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_file(input bit mark_start);
        foreach (file_bytes[i])
            push_byte(file_bytes[i], mark_start && (i == 0));
    endtask

    task automatic add_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            file_bytes.push_back(w[8*i +: 8]);
    endtask

    // Random TIM file: mostly well formed, some bad magic, truncated or trailed by junk
    task automatic build_file();
        int unsigned pick;
        int unsigned depth;
        int unsigned clut_n;
        int unsigned pw;
        int unsigned ph;
        int unsigned iw;
        int unsigned ih;
        int unsigned nbytes;
        logic [31:0] flags_w;
        logic [7:0]  b;
        bit          with_clut;
        file_bytes.delete();
        clut_n = 0;
        pick = $urandom_range(0, 99);
        if (pick < 7)
        begin
            // bad magic: a single flipped bit or a random word
            add_word(pick < 3 ? MAGIC_WORD ^ (32'd1 << $urandom_range(0, 31)) : $urandom);
            repeat ($urandom_range(0, 5))
                file_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        add_word(MAGIC_WORD);
        with_clut = ($urandom_range(0, 9) < 7);
        pick = $urandom_range(0, 9);
        if (pick < 4)
            depth = 0;
        else if (pick < 7)
            depth = DEPTH_8BPP;
        else if (pick < 9)
            depth = DEPTH_16BPP;
        else
            depth = $urandom_range(3, 7);
        flags_w          = $urandom;
        flags_w[FLAG_CLUT] = with_clut;
        flags_w[2:0]     = 3'(depth);
        add_word(flags_w);
        if (with_clut)
        begin
            add_word($urandom);
            add_word($urandom);
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                // empty palette: one dimension zero
                if ($urandom_range(0, 1))
                begin
                    pw = 0;
                    ph = $urandom_range(0, 65535);
                end
                else
                begin
                    pw = $urandom_range(0, 65535);
                    ph = 0;
                end
            end
            else if (pick == 1)
            begin
                pw = 16;
                ph = 16;
            end
            else if (pick == 2)
            begin
                // longer than the store
                pw = $urandom_range(17, 20);
                ph = 16;
            end
            else
            begin
                pw = $urandom_range(1, 8);
                ph = $urandom_range(1, 2);
            end
            add_word({ph[15:0], pw[15:0]});
            clut_n = pw * ph;
            // two bytes per palette colour
            repeat (clut_n)
            begin
                file_bytes.push_back(8'($urandom_range(0, 255)));
                file_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        add_word($urandom);
        add_word($urandom);
        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            if ($urandom_range(0, 1))
            begin
                iw = 0;
                ih = $urandom_range(0, 65535);
            end
            else
            begin
                iw = $urandom_range(0, 65535);
                ih = 0;
            end
        end
        else if (pick == 1)
        begin
            iw = 16'hFFFF;
            ih = 16'hFFFF;
        end
        else if (pick == 2)
        begin
            iw = 16'hFFFF;
            ih = 1;
        end
        else
        begin
            iw = $urandom_range(1, 3);
            ih = $urandom_range(1, 3);
        end
        add_word({ih[15:0], iw[15:0]});
        // every depth takes two bytes per width word per row
        if (iw == 0 || ih == 0)
            nbytes = 0;
        else if (iw * ih > 20)
            nbytes = $urandom_range(8, 40);
        else
            nbytes = 2 * iw * ih;
        repeat (nbytes)
        begin
            b = 8'($urandom_range(0, 255));
            if (depth == DEPTH_8BPP && clut_n != 0 && $urandom_range(0, 1))
                b = 8'($urandom_range(0, (clut_n > 256 ? 256 : clut_n) - 1));
            file_bytes.push_back(b);
        end
        if ($urandom_range(0, 9) == 0)
        begin
            // cut short; the next file start interrupts it
            pick = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > pick)
                void'(file_bytes.pop_back());
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            repeat ($urandom_range(1, 4))
                file_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: 16bpp file straight after reset with no file start,
        // extreme colours, then one byte past the last pixel
        file_bytes.delete();
        add_word(MAGIC_WORD);
        add_word({29'd0, DEPTH_16BPP});
        add_word(32'h0000_0014);
        add_word(32'h0000_0000);
        add_word({16'd1, 16'd2});
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hA5);
        send_file(1'b0);

        // Random files
        while (bytes_sent < BYTE_TARGET)
        begin
            build_file();
            send_file(1'b1);
        end
        src_valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (board.errors == 0 && board.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== tim_image_stream_decoder_top.f =====
design/tim_dec_pkg.sv
design/tim_dec_parser.sv
design/tim_dec_palette.sv
design/tim_dec_out.sv
design/tim_image_stream_decoder_top.sv
bench/tim_image_stream_decoder_top_tb.sv
